### design/fpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes, the classified request type and a saturation helper.
// ----------------------------------------------------------------------------
package fpa_pkg;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_CMP    = 4'd4,
      OP_MIN    = 4'd5,
      OP_MAX    = 4'd6,
      OP_INC    = 4'd7,
      OP_DEC    = 4'd8,
      OP_TO_INT = 4'd9
   } op_type;

   // How the back end finishes a request.
   typedef enum logic [1:0] {
      KIND_DONE = 2'd0,
      KIND_MUL  = 2'd1,
      KIND_DIV  = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] mag_a;
      logic [31:0] mag_b;
      logic        neg;
      logic        lt;
      logic        eq;
      logic        gt;
      logic [31:0] res;
      logic        sat;
      logic        dz;
   } item_type;

   typedef struct packed {
      logic [31:0] res;
      logic        sat;
   } clamp_type;

   localparam logic [31:0] MAX_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] MAX_NEG = 32'h8000_0000;

   // Apply a sign to a magnitude and clamp it to 32 signed bits.
   function automatic clamp_type clamp_mag(input logic neg, input logic [63:0] mag);
      clamp_type c;
      c.sat = 1'b0;
      if (neg) begin
         if (mag > 64'h8000_0000) begin
            c.sat = 1'b1;
            c.res = MAX_NEG;
         end else begin
            c.res = 32'd0 - mag[31:0];
         end
      end else begin
         if (mag > 64'h7FFF_FFFF) begin
            c.sat = 1'b1;
            c.res = MAX_POS;
         end else begin
            c.res = mag[31:0];
         end
      end
      return c;
   endfunction

endpackage

### design/fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// Path: front-end register, two-entry queue, entry stage, divider stages, output register.
// Throughput: one request per cycle while results are taken; the divider has one stage per quotient bit.
// A stalled result freezes the back-end pipeline; the queue lets the front accept until it is full.
// Reset: synchronous, active high; clears all valid state, payload is not reset.
// ----------------------------------------------------------------------------
// Fixed-point ALU top level
// Signed fixed-point arithmetic unit with saturation on a request stream.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
   parameter int FRAC_BITS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // operand_a[31:0], operand_b[63:32]
   input  logic [3:0]  req_tuser,  // op[3:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata   // result_raw[31:0], a_less[32], a_equal[33],
                                   // a_greater[34], saturated[35],
                                   // divide_by_zero[36], zero fill[39:37]
);
   import fpa_pkg::*;

   logic     push, full, pop, empty;
   item_type push_item, pop_item;

   fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_op      (req_tuser),
      .in_a       (req_tdata[31:0]),
      .in_b       (req_tdata[63:32]),
      .push       (push),
      .push_item  (push_item),
      .queue_full (full)
   );

   fpa_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .empty     (empty),
      .pop_item  (pop_item)
   );

   fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock       (clock),
      .reset       (reset),
      .pop         (pop),
      .queue_empty (empty),
      .pop_item    (pop_item),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_data    (rsp_tdata)
   );

endmodule

### design/fpa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts requests, finishes the simple operations and tags mul and div by a nonzero divisor.
// ----------------------------------------------------------------------------
module fpa_front #(
   parameter int FRAC_BITS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [3:0]       in_op,
   input  logic [31:0]      in_a,
   input  logic [31:0]      in_b,
   output logic             push,
   output fpa_pkg::item_type push_item,
   input  logic             queue_full
);
   import fpa_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff, item_in;

   // Saturating 33-bit signed sum to 32 bits.
   function automatic clamp_type sat_sum(input logic [32:0] s);
      clamp_type c;
      c.sat = (s[32] != s[31]);
      c.res = c.sat ? (s[32] ? MAX_NEG : MAX_POS) : s[31:0];
      return c;
   endfunction

   logic [32:0] a_ext, b_ext, round_sum, int_mag;
   logic        a_lt_b;
   clamp_type   c_add, c_sub, c_inc, c_dec;

   // Classify and compute the simple operations.
   always_comb begin
      a_ext     = {in_a[31], in_a};
      b_ext     = {in_b[31], in_b};
      a_lt_b    = $signed(in_a) < $signed(in_b);
      c_add     = sat_sum(a_ext + b_ext);
      c_sub     = sat_sum(a_ext - b_ext);
      c_inc     = sat_sum(a_ext + 33'd1);
      c_dec     = sat_sum(a_ext - 33'd1);
      item_in.mag_a = in_a[31] ? 32'd0 - in_a : in_a;
      item_in.mag_b = in_b[31] ? 32'd0 - in_b : in_b;
      round_sum = {1'b0, item_in.mag_a} + (33'd1 << (FRAC_BITS - 1));
      int_mag   = round_sum >> FRAC_BITS;
      item_in.neg  = in_a[31] ^ in_b[31];
      item_in.lt   = a_lt_b;
      item_in.eq   = (in_a == in_b);
      item_in.gt   = !a_lt_b && (in_a != in_b);
      item_in.kind = KIND_DONE;
      item_in.res  = 32'd0;
      item_in.sat  = 1'b0;
      item_in.dz   = 1'b0;
      case (in_op)
         OP_ADD: begin
            item_in.res = c_add.res;
            item_in.sat = c_add.sat;
         end
         OP_SUB: begin
            item_in.res = c_sub.res;
            item_in.sat = c_sub.sat;
         end
         OP_MUL: item_in.kind = KIND_MUL;
         OP_DIV: begin
            if (in_b == 32'd0) begin
               item_in.dz  = 1'b1;
               item_in.sat = 1'b1;
               item_in.res = in_a[31] ? MAX_NEG : MAX_POS;
            end else begin
               item_in.kind = KIND_DIV;
            end
         end
         OP_CMP: item_in.res = 32'd0;
         OP_MIN: item_in.res = a_lt_b ? in_a : in_b;
         OP_MAX: item_in.res = item_in.gt ? in_a : in_b;
         OP_INC: begin
            item_in.res = c_inc.res;
            item_in.sat = c_inc.sat;
         end
         OP_DEC: begin
            item_in.res = c_dec.res;
            item_in.sat = c_dec.sat;
         end
         OP_TO_INT: item_in.res = in_a[31] ? 32'd0 - int_mag[31:0] : int_mag[31:0];
         default: item_in.res = 32'd0;
      endcase
   end

   // Hand the classified request to the queue when it has room.
   assign push      = valid_ff && !queue_full;
   assign in_ready  = !valid_ff || !queue_full;
   assign push_item = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_valid && in_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

### design/fpa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU request queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
module fpa_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  fpa_pkg::item_type push_item,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output fpa_pkg::item_type pop_item
);
   import fpa_pkg::*;

   item_type    mem_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

### design/fpa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Multiplier and one-bit-per-stage divider pipeline with output register.
// ----------------------------------------------------------------------------
module fpa_back #(
   parameter int FRAC_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   output logic              pop,
   input  logic              queue_empty,
   input  fpa_pkg::item_type pop_item,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [39:0]       out_data
);
   import fpa_pkg::*;

   localparam int N = 32 + FRAC_BITS;

   logic          v_ff    [N+1];
   item_type      it_ff   [N+1];
   logic [63:0]   prod_ff [N+1];
   logic [31:0]   rem_ff  [N+1];
   logic [N-1:0]  num_ff  [N+1];
   logic [N-1:0]  quo_ff  [N+1];

   logic          adv;
   logic          out_v_ff, out_v_in;
   logic [39:0]   out_data_ff, out_data_in;

   // The whole pipeline moves when the output register is empty or its result is taken.
   assign adv       = !out_v_ff || out_ready;
   assign pop       = adv && !queue_empty;
   assign out_valid = out_v_ff;
   assign out_data  = out_data_ff;

   // Entry stage: multiply magnitudes and load the dividend.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= pop;
      end
      if (adv) begin
         it_ff[0]   <= pop_item;
         prod_ff[0] <= 64'(pop_item.mag_a) * 64'(pop_item.mag_b);
         rem_ff[0]  <= 32'd0;
         num_ff[0]  <= {pop_item.mag_a, FRAC_BITS'(0)};
         quo_ff[0]  <= '0;
      end
   end

   // Restoring division, one quotient bit per stage.
   for (genvar k = 1; k <= N; k++) begin : g_div
      logic [32:0] trial;
      logic        take;
      always_comb begin
         trial = {rem_ff[k-1], num_ff[k-1][N-1]};
         take  = trial >= {1'b0, it_ff[k-1].mag_b};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
         if (adv) begin
            it_ff[k]   <= it_ff[k-1];
            prod_ff[k] <= prod_ff[k-1];
            rem_ff[k]  <= take ? 32'(trial - {1'b0, it_ff[k-1].mag_b}) : trial[31:0];
            num_ff[k]  <= num_ff[k-1] << 1;
            quo_ff[k]  <= {quo_ff[k-1][N-2:0], take};
         end
      end
   end

   // Rounding and clamping of the long operations.
   item_type    fin;
   logic [63:0] mul_q, div_q;
   logic        div_up;
   clamp_type   c;

   always_comb begin
      fin    = it_ff[N];
      mul_q  = (prod_ff[N] + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
      div_up = {rem_ff[N], 1'b0} >= {1'b0, fin.mag_b};
      div_q  = 64'(quo_ff[N]) + 64'(div_up);
      c.res  = fin.res;
      c.sat  = fin.sat;
      case (fin.kind)
         KIND_MUL: c = clamp_mag(fin.neg && (mul_q != 64'd0), mul_q);
         KIND_DIV: c = clamp_mag(fin.neg && (div_q != 64'd0), div_q);
         default: c = c;
      endcase
      out_data_in = {3'd0, fin.dz, c.sat, fin.gt, fin.eq, fin.lt, c.res};
      out_v_in    = adv ? v_ff[N] : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (adv) begin
         out_data_ff <= out_data_in;
      end
   end

endmodule

### bench/tb_fixed_point_alu_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fixed-point ALU unit testbench
// Sends operation requests, predicts each result from exact integer math
// and compares every response field but the zero fill in order, under varied idle and stall.
// ----------------------------------------------------------------------------
module tb_fixed_point_alu_unit;
   import fpa_pkg::*;

   localparam int FRAC_BITS = 8;
   localparam int LATENCY   = FRAC_BITS + 35;

   // Packed from the top bit down, so result_raw lands in the low 32 bits.
   typedef struct packed {
      logic        divide_by_zero;
      logic        saturated;
      logic        a_greater;
      logic        a_equal;
      logic        a_less;
      logic [31:0] result_raw;
   } alu_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;

   alu_result_type pending_results[$];
   int  error_count;
   int  send_idle_pct;
   int  recv_stall_pct;

   fixed_point_alu_unit #(.FRAC_BITS(FRAC_BITS)) u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Clock with a 10 ns period.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Sign a magnitude and clamp it to 32 signed bits.
   function automatic logic [32:0] sign_clamp(input logic neg, input logic [63:0] mag);
      if (neg) begin
         if (mag > 64'h8000_0000) return {1'b1, 32'h8000_0000};
         return {1'b0, 32'd0 - mag[31:0]};
      end
      if (mag > 64'h7FFF_FFFF) return {1'b1, 32'h7FFF_FFFF};
      return {1'b0, mag[31:0]};
   endfunction

   // Clamp a wide signed sum to 32 bits.
   function automatic logic [32:0] range_clamp(input longint v);
      if (v > 64'sd2147483647) return {1'b1, 32'h7FFF_FFFF};
      if (v < -64'sd2147483648) return {1'b1, 32'h8000_0000};
      return {1'b0, v[31:0]};
   endfunction

   // Exact integer prediction of one ALU operation.
   function automatic alu_result_type compute_alu(input logic [3:0] op,
                                                  input logic [31:0] a_bits,
                                                  input logic [31:0] b_bits);
      alu_result_type r;
      longint a, b;
      logic [63:0] ma, mb, p, q, num;
      logic neg;
      logic [32:0] c;
      a = longint'($signed(a_bits));
      b = longint'($signed(b_bits));
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      neg = (a < 0) != (b < 0);
      c = 33'd0;
      r.divide_by_zero = 1'b0;
      case (op)
         OP_ADD: c = range_clamp(a + b);
         OP_SUB: c = range_clamp(a - b);
         OP_MUL: begin
            p = ma * mb;
            q = (p + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            c = sign_clamp(neg && q != 0, q);
         end
         OP_DIV: begin
            if (b == 0) begin
               r.divide_by_zero = 1'b1;
               c = {1'b1, (a >= 0) ? 32'h7FFF_FFFF : 32'h8000_0000};
            end else begin
               num = ma << FRAC_BITS;
               q = (2 * num + mb) / (2 * mb);
               c = sign_clamp(neg && q != 0, q);
            end
         end
         OP_MIN: c = {1'b0, (a < b) ? a_bits : b_bits};
         OP_MAX: c = {1'b0, (a > b) ? a_bits : b_bits};
         OP_INC: c = range_clamp(a + 1);
         OP_DEC: c = range_clamp(a - 1);
         OP_TO_INT: begin
            q = (ma + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            c = sign_clamp(a < 0 && q != 0, q);
         end
         default: c = 33'd0;
      endcase
      r.result_raw = c[31:0];
      r.saturated  = c[32];
      r.a_less     = a < b;
      r.a_equal    = a == b;
      r.a_greater  = a > b;
      return r;
   endfunction

   // Send one request and record its expected result when accepted.
   task automatic send_request(input logic [3:0] op, input logic [31:0] a,
                               input logic [31:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {b, a};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(compute_alu(op, a, b));
   endtask

   // Receiver stall and response checking.
   always @(posedge clock) begin
      alu_result_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[36:0];
            if (pending_results.size() == 0) begin
               $error("unexpected response %h", rsp_tdata);
               error_count++;
            end else begin
               want = pending_results.pop_front();
               if (got.result_raw !== want.result_raw) begin
                  $error("result_raw expected %h actual %h", want.result_raw, got.result_raw);
                  error_count++;
               end
               if (got.a_less !== want.a_less) begin
                  $error("a_less expected %b actual %b", want.a_less, got.a_less);
                  error_count++;
               end
               if (got.a_equal !== want.a_equal) begin
                  $error("a_equal expected %b actual %b", want.a_equal, got.a_equal);
                  error_count++;
               end
               if (got.a_greater !== want.a_greater) begin
                  $error("a_greater expected %b actual %b", want.a_greater, got.a_greater);
                  error_count++;
               end
               if (got.saturated !== want.saturated) begin
                  $error("saturated expected %b actual %b", want.saturated, got.saturated);
                  error_count++;
               end
               if (got.divide_by_zero !== want.divide_by_zero) begin
                  $error("divide_by_zero expected %b actual %b",
                         want.divide_by_zero, got.divide_by_zero);
                  error_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Operand drawn to favor extremes, small values and exact halves.
   function automatic logic [31:0] pick_operand();
      case ($urandom_range(7))
         0: return 32'h7FFF_FFFF - $urandom_range(2);
         1: return 32'h8000_0000 + $urandom_range(2);
         2: return $urandom_range(1024) - 512;
         3: return {$urandom_range(1) ? 24'hFFFFFF : 24'h0, 8'h80};
         4: return 32'd0;
         default: return $urandom;
      endcase
   endfunction

   // Extremes of every field and each special case.
   task automatic test_directed();
      logic [3:0] op;
      send_request(OP_ADD, 32'h7FFF_FFFF, 32'd1);
      send_request(OP_SUB, 32'h8000_0000, 32'd1);
      send_request(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_request(OP_MUL, 32'h8000_0000, 32'h0000_0100);
      send_request(OP_MUL, 32'hFFFF_FF80, 32'h0000_0001);
      send_request(OP_MUL, 32'h0000_0180, 32'h0000_0080);
      send_request(OP_DIV, 32'h0000_0100, 32'd0);
      send_request(OP_DIV, 32'hFFFF_FFFF, 32'd0);
      send_request(OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
      send_request(OP_DIV, 32'h0000_0001, 32'h0000_0200);
      send_request(OP_DIV, 32'hFFFF_FFFF, 32'h0000_0200);
      send_request(OP_CMP, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_INC, 32'h7FFF_FFFF, 32'd5);
      send_request(OP_DEC, 32'h8000_0000, 32'd5);
      send_request(OP_TO_INT, 32'h0000_0180, 32'd0);
      send_request(OP_TO_INT, 32'hFFFF_FE80, 32'd0);
      send_request(OP_TO_INT, 32'h8000_0000, 32'h8000_0000);
      for (int i = 10; i < 16; i++) begin
         op = 4'(i);
         send_request(op, 32'h1234_5678, 32'h1234_5678);
      end
   endtask

   // Random requests in one idle and stall setting.
   task automatic test_random(input int count, input int idle_pct, input int stall_pct);
      logic [3:0] op;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) begin
         op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10)) : 4'($urandom_range(9));
         if ($urandom_range(3) == 0) send_request(op, $urandom, $urandom);
         else send_request(op, pick_operand(), pick_operand());
      end
   endtask

   initial begin
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 64'd0;
      req_tuser  <= 4'd0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(185, 0, 0);
      test_random(185, 45, 0);
      test_random(185, 0, 45);
      test_random(185, 19, 19);
      test_random(185, 0, 0);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0)
         $display("tb_fixed_point_alu_unit passed");
      else
         $display("tb_fixed_point_alu_unit failed");
      $finish;
   end

   // Timeout guard.
   initial begin
      #2000000;
      $display("tb_fixed_point_alu_unit failed");
      $finish;
   end

endmodule
